// File: rtl/llba_pkg.sv
package llba_pkg;

  localparam int MAX_BINS    = 16;
  localparam int LOAD_WIDTH  = 32;
  localparam int BIN_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W       = $clog2(MAX_BINS + 1);
  localparam int HEIGHT_W    = 16;
  localparam int TOWERS_W    = 5;
  localparam int LIMIT_W     = 16;
  localparam int BIN_INDEX_W = 4;
  // wide enough for a load and for the 16-bit height / limit fields
  localparam int EXT_W       = (LOAD_WIDTH > 16) ? LOAD_WIDTH : 16;

  // register indexes on the APB port (byte address 4*index)
  localparam logic REG_NUM_TOWERS   = 1'b0;
  localparam logic REG_SPREAD_LIMIT = 1'b1;

  typedef logic [LOAD_WIDTH-1:0] load_t;

  typedef enum logic [1:0] {
    ALU_ADD_SAT,
    ALU_SUB,
    ALU_LT,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    load_t res;
    logic  flag;  // carry on add, a<b on LT/SUB, a>b on GT
  } alu_res_t;

endpackage

// File: rtl/least_loaded_bin_assigner_top.sv
// Least-loaded bin assigner.
// Input stream (s_*): one transaction per item, s_tdata[15:0] = block height,
// s_tlast = last item of a run. Output stream (m_*): one transaction per item,
// m_tdata[3:0] = chosen bin index, m_tdata[4] = spread ok, m_tlast = verdict
// present (result of the last item of a run).
// Configure over APB while idle: 0x0 num_towers, 0x4 spread_limit.
// Each item scans the n active bin loads through one shared ALU, reading the
// load RAM one entry per cycle, then writes back the saturated sum.
// Sequence, n = active bins: a plain item scans the n loads, writes back the
// chosen bin, then presents its result until taken. A last item adds a verdict
// pass reading each load twice (min, then max) before its result is presented.
// One item at a time: s_tready is high only while idle; the result is held
// in m_tdata until m_tready, and no new item is taken before that.
// Reset (rst, synchronous) clears all loads through per-bin valid bits, sets
// num_towers to 1 and spread_limit to 0. The last item of a run clears all
// loads the same way. No clearing pass is needed.
module least_loaded_bin_assigner_top (
  input  logic        clk,
  input  logic        rst,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] block_height
  input  logic        s_tlast,   // last_item
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] bin_index, [4] spread_ok, [7:5] zero
  output logic        m_tlast    // verdict_valid
);

  localparam int LW    = llba_pkg::LOAD_WIDTH;
  localparam int BIN_W = llba_pkg::BIN_W;
  localparam int CNT_W = llba_pkg::CNT_W;
  localparam int EXT_W = llba_pkg::EXT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_VPRE,
    S_VLO,
    S_VHI,
    S_DIFF,
    S_CMP,
    S_OUT
  } state_t;

  state_t state;

  logic [llba_pkg::TOWERS_W-1:0] num_towers;
  logic [llba_pkg::LIMIT_W-1:0]  spread_limit;

  logic [llba_pkg::HEIGHT_W-1:0] height;
  logic                          last;
  logic [BIN_W-1:0]              ridx;
  logic [BIN_W-1:0]              didx;
  logic [llba_pkg::MAX_BINS-1:0] vld;
  logic [BIN_W-1:0]              best;
  llba_pkg::load_t               best_load;
  llba_pkg::load_t               lo;
  llba_pkg::load_t               hi;
  llba_pkg::load_t               diff;
  logic                          ok;

  logic [CNT_W-1:0]      n_bins;
  logic [BIN_W-1:0]      n_last;
  llba_pkg::load_t       ram_q;
  llba_pkg::load_t       ld;
  llba_pkg::load_t       wr_data;
  llba_pkg::alu_op_t     alu_op;
  llba_pkg::load_t       alu_a;
  llba_pkg::load_t       alu_b;
  llba_pkg::alu_res_t    alu;
  logic [EXT_W-1:0]      hgt_ext;
  logic [EXT_W-1:0]      lim_ext;
  logic                  hgt_hi;
  logic                  lim_hi;
  logic [BIN_W+3:0]      best_wide;
  logic                  cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_towers   <= llba_pkg::TOWERS_W'(1);
      spread_limit <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        llba_pkg::REG_NUM_TOWERS:   num_towers   <= pwdata[llba_pkg::TOWERS_W-1:0];
        llba_pkg::REG_SPREAD_LIMIT: spread_limit <= pwdata[llba_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      llba_pkg::REG_NUM_TOWERS: prdata = 32'(num_towers);
      default:                  prdata = 32'(spread_limit);
    endcase
  end

  // zero means one bin; above the built maximum saturates
  always_comb begin
    if (num_towers == '0) begin
      n_bins = CNT_W'(1);
    end else if (32'(num_towers) > 32'(llba_pkg::MAX_BINS)) begin
      n_bins = CNT_W'(llba_pkg::MAX_BINS);
    end else begin
      n_bins = CNT_W'(num_towers);
    end
  end
  assign n_last = BIN_W'(n_bins - CNT_W'(1));

  // ---------------- datapath ----------------
  llba_ram #(
    .WIDTH(LW),
    .DEPTH(llba_pkg::MAX_BINS)
  ) u_load_ram (
    .clk    (clk),
    .wr_en  (state == S_ADD),
    .wr_addr(best),
    .wr_data(wr_data),
    .rd_addr(ridx),
    .rd_data(ram_q)
  );

  // bins not written in this run read as zero
  assign ld = vld[didx] ? ram_q : '0;

  assign hgt_ext = EXT_W'(height);
  assign lim_ext = EXT_W'(spread_limit);
  assign hgt_hi  = |(hgt_ext >> LW);
  assign lim_hi  = |(lim_ext >> LW);

  always_comb begin
    alu_op = llba_pkg::ALU_LT;
    alu_a  = ld;
    alu_b  = best_load;
    case (state)
      S_ADD: begin
        alu_op = llba_pkg::ALU_ADD_SAT;
        alu_a  = best_load;
        alu_b  = hgt_ext[LW-1:0];
      end
      S_VLO: begin
        alu_op = llba_pkg::ALU_LT;
        alu_b  = lo;
      end
      S_VHI: begin
        alu_op = llba_pkg::ALU_GT;
        alu_b  = hi;
      end
      S_DIFF: begin
        alu_op = llba_pkg::ALU_SUB;
        alu_a  = hi;
        alu_b  = lo;
      end
      S_CMP: begin
        alu_op = llba_pkg::ALU_LT;
        alu_a  = lim_ext[LW-1:0];
        alu_b  = diff;
      end
      default: ;
    endcase
  end

  llba_alu u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .r (alu)
  );

  assign wr_data = hgt_hi ? '1 : alu.res;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    didx <= ridx;  // RAM read is registered: ram_q belongs to last cycle's address
    if (rst) begin
      state <= S_IDLE;
      ridx  <= '0;
      vld   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            height <= s_tdata;
            last   <= s_tlast;
            ridx   <= (n_last != '0) ? BIN_W'(1) : '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (didx == '0) begin
            best      <= '0;
            best_load <= ld;
          end else if (alu.flag) begin
            best      <= didx;
            best_load <= ld;
          end
          if (ridx != n_last) begin
            ridx <= ridx + 1'b1;
          end
          if (didx == n_last) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          vld[best] <= 1'b1;
          ridx      <= '0;
          ok        <= 1'b0;
          state     <= last ? S_VPRE : S_OUT;
        end
        S_VPRE: begin
          state <= S_VLO;
        end
        S_VLO: begin
          if (didx == '0 || alu.flag) begin
            lo <= ld;
          end
          if (ridx != n_last) begin
            ridx <= ridx + 1'b1;
          end
          state <= S_VHI;
        end
        S_VHI: begin
          if (didx == '0 || alu.flag) begin
            hi <= ld;
          end
          state <= (didx == n_last) ? S_DIFF : S_VLO;
        end
        S_DIFF: begin
          diff  <= alu.res;
          state <= S_CMP;
        end
        S_CMP: begin
          ok    <= lim_hi || !alu.flag;
          vld   <= '0;
          ridx  <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign best_wide = {4'b0000, best};
  assign m_tdata   = {3'b000, ok, best_wide[llba_pkg::BIN_INDEX_W-1:0]};
  assign m_tlast   = last;

  // ---------------- checks ----------------
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("item accepted while another is in flight");

  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready)
    else $error("not ready after result taken");

  a_ok_only_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[4])
    else $error("spread_ok set without verdict");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> vld == '0)
    else $error("loads not cleared at end of run");

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {{CNT_W{1'b0}}, best} < {{BIN_W{1'b0}}, n_bins})
    else $error("chosen bin outside active count");

endmodule

// File: rtl/llba_ram.sv
module llba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/llba_alu.sv
module llba_alu (
  input  llba_pkg::alu_op_t  op,
  input  llba_pkg::load_t    a,
  input  llba_pkg::load_t    b,
  output llba_pkg::alu_res_t r
);

  localparam int LW = llba_pkg::LOAD_WIDTH;

  logic [LW:0] x;
  logic [LW:0] y;
  logic [LW:0] s;
  logic        sub;

  // one adder/subtractor; GT swaps the operands and reads the borrow
  always_comb begin
    x   = (op == llba_pkg::ALU_GT) ? {1'b0, b} : {1'b0, a};
    y   = (op == llba_pkg::ALU_GT) ? {1'b0, a} : {1'b0, b};
    sub = (op != llba_pkg::ALU_ADD_SAT);
    s   = sub ? (x - y) : (x + y);
    r.flag = s[LW];
    case (op)
      llba_pkg::ALU_ADD_SAT: r.res = s[LW] ? '1 : s[LW-1:0];
      default:               r.res = s[LW-1:0];
    endcase
  end

endmodule
